// ===== hw/rtl/alks_pkg.sv =====
// Shared types, constants and classification functions for the keypad scanner.
package alks_pkg;

   // Item kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // Register indexes
   localparam logic CSR_REPEAT_START  = 1'b0;
   localparam logic CSR_REPEAT_PERIOD = 1'b1;

   // Reset values of the registers
   localparam logic signed [10:0] REPEAT_START_RST  = -11'sd20;
   localparam logic        [9:0]  REPEAT_PERIOD_RST = 10'd10;

   // Key codes
   localparam logic [2:0] KEY_NONE  = 3'd0;
   localparam logic [2:0] KEY_INC   = 3'd1;
   localparam logic [2:0] KEY_DEC   = 3'd2;
   localparam logic [2:0] KEY_CHAN  = 3'd3;
   localparam logic [2:0] KEY_MROOM = 3'd4;
   localparam logic [2:0] KEY_POWER = 3'd5;

   // Aux band codes
   localparam logic [2:0] AUX_NONE  = 3'd0;
   localparam logic [2:0] AUX_BAND1 = 3'd1;
   localparam logic [2:0] AUX_BAND2 = 3'd2;
   localparam logic [2:0] AUX_BAND3 = 3'd3;
   localparam logic [2:0] AUX_BAND4 = 3'd4;

   // Sample jump limit that restarts averaging
   localparam logic [9:0] JUMP_LIMIT = 10'd115;

   typedef struct packed {
      logic       req_type;
      logic [9:0] key_sample;
      logic [9:0] aux_sample;
      logic       power_pressed;
   } alks_req_type;

   typedef struct packed {
      logic [2:0] held_code;
      logic [2:0] aux_code;
      logic [2:0] press_event;
      logic [2:0] repeat_event;
   } alks_rsp_type;

   // Events produced by one scan tick
   typedef struct packed {
      logic [2:0] press;
      logic [2:0] repeat_code;
   } alks_tick_evt_type;

   // Mean voltage windows, upper bound inclusive
   function automatic logic [2:0] classify_key(input logic [15:0] mean);
      logic [2:0] code;
      code = KEY_NONE;
      if (mean > 16'd860)      code = KEY_NONE;
      else if (mean > 16'd820) code = KEY_INC;
      else if (mean > 16'd750) code = KEY_NONE;
      else if (mean > 16'd710) code = KEY_DEC;
      else if (mean > 16'd640) code = KEY_NONE;
      else if (mean > 16'd600) code = KEY_CHAN;
      else if (mean > 16'd380) code = KEY_NONE;
      else if (mean > 16'd340) code = KEY_MROOM;
      return code;
   endfunction

   // Aux windows, both bounds exclusive
   function automatic logic [2:0] classify_aux(input logic [9:0] a);
      logic [2:0] code;
      code = AUX_NONE;
      if (a < 10'h0D8 && a > 10'h0B8)      code = AUX_BAND1;
      else if (a < 10'h1B0 && a > 10'h188) code = AUX_BAND2;
      else if (a < 10'h288 && a > 10'h248) code = AUX_BAND3;
      else if (a < 10'h340 && a > 10'h314) code = AUX_BAND4;
      return code;
   endfunction

endpackage

// ===== hw/rtl/adc_ladder_keypad_scanner.sv =====
// Resistor-ladder keypad scanner: sample averaging, key/aux classing, debounce.
// A beat passes through the input reg and then the result reg before it is valid on rsp.
// Throughput: one beat per cycle while the result reg drains (rsp_ready high or empty);
// all state updates in the single pass from input reg.
// Reset (synchronous, active high) clears all key, averaging and repeat state,
// empties both registers, and loads repeat_start = -20, repeat_period = 10.
// No clearing pass: the block takes beats in the first cycle after reset.
module adc_ladder_keypad_scanner import alks_pkg::*; #(
   parameter int AVG_SHIFT = 3
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  alks_req_type        req_data,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output alks_rsp_type        rsp_data,
   // register writes
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [10:0]         csr_wdata
);

   // Sample counter only needs to reach 2^AVG_SHIFT
   localparam int CNT_W = AVG_SHIFT + 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(1) << AVG_SHIFT;

   // Config registers
   logic signed [10:0] repeat_start_ff;
   logic [9:0]         repeat_period_ff;

   // Input register
   logic               in_valid_ff;
   alks_req_type       in_data_ff;

   // Result register
   logic               rsp_valid_ff;
   alks_rsp_type       rsp_data_ff, rsp_data_in;
   logic               rsp_tick_ff;

   // Averaging and classification state
   logic [9:0]         last_ff, last_in;
   logic [15:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [2:0]         held_ff, held_in;
   logic [2:0]         aux_ff, aux_in;

   logic               advance;
   logic               work;
   logic               is_tick;
   logic [9:0]         diff;
   logic [15:0]        sum_add;
   logic [CNT_W-1:0]   cnt_inc;
   alks_tick_evt_type  tick_evt;

   // Result register drains or is empty -> the input register may move on
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign work      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign is_tick   = (in_data_ff.req_type == REQ_TICK);

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_start_ff  <= REPEAT_START_RST;
         repeat_period_ff <= REPEAT_PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REPEAT_START:  repeat_start_ff  <= csr_wdata;
            CSR_REPEAT_PERIOD: repeat_period_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
   end

   // Sample path: jump check, accumulate, classify on a full window
   assign diff    = (in_data_ff.key_sample > last_ff) ? in_data_ff.key_sample - last_ff
                                                       : last_ff - in_data_ff.key_sample;
   assign sum_add = sum_ff + {6'b0, in_data_ff.key_sample};
   assign cnt_inc = cnt_ff + CNT_W'(1);

   always_comb begin
      last_in = last_ff;
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      held_in = held_ff;
      aux_in  = aux_ff;
      if (!is_tick) begin
         last_in = in_data_ff.key_sample;
         if (diff > JUMP_LIMIT) begin
            sum_in = '0;
            cnt_in = '0;
         end else if (cnt_inc == CNT_FULL) begin
            sum_in  = '0;
            cnt_in  = '0;
            held_in = in_data_ff.power_pressed ? KEY_POWER : classify_key(sum_add >> AVG_SHIFT);
            aux_in  = classify_aux(in_data_ff.aux_sample);
         end else begin
            sum_in = sum_add;
            cnt_in = cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         sum_ff  <= '0;
         cnt_ff  <= '0;
         held_ff <= KEY_NONE;
         aux_ff  <= AUX_NONE;
      end else if (work) begin
         last_ff <= last_in;
         sum_ff  <= sum_in;
         cnt_ff  <= cnt_in;
         held_ff <= held_in;
         aux_ff  <= aux_in;
      end
   end

   // Tick path: debounce and auto-repeat, sees the current held key
   alks_tick u_tick (
      .clock         (clock),
      .reset         (reset),
      .tick_en       (work && is_tick),
      .held_key      (held_ff),
      .repeat_start  (repeat_start_ff),
      .repeat_period (repeat_period_ff),
      .tick_evt      (tick_evt)
   );

   always_comb begin
      rsp_data_in.held_code    = held_in;
      rsp_data_in.aux_code     = aux_in;
      rsp_data_in.press_event  = is_tick ? tick_evt.press : KEY_NONE;
      rsp_data_in.repeat_event = is_tick ? tick_evt.repeat_code : KEY_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (work) begin
         rsp_data_ff <= rsp_data_in;
         rsp_tick_ff <= is_tick;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Assertions
   a_cnt_below_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != CNT_FULL)
      else $error("sample count reached window size");

   a_sample_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tick_ff |->
         rsp_data_ff.press_event == KEY_NONE && rsp_data_ff.repeat_event == KEY_NONE)
      else $error("event on a sample beat");

   a_held_in_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= KEY_POWER && aux_ff <= AUX_BAND4)
      else $error("held or aux code out of range");

   a_work_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      work |=> rsp_valid_ff)
      else $error("processed beat lost");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled with room");

endmodule

// ===== hw/rtl/alks_tick.sv =====
// Scan-tick logic: two-read debounce and auto-repeat counter.
module alks_tick import alks_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick_en,
   input  logic [2:0]           held_key,
   input  logic signed [10:0]   repeat_start,
   input  logic [9:0]           repeat_period,
   output alks_tick_evt_type    tick_evt
);

   logic [2:0]         confirmed_ff, confirmed_in;
   logic [2:0]         candidate_ff, candidate_in;
   logic [2:0]         ref_key_ff, ref_key_in;
   logic signed [11:0] rpt_cnt_ff, rpt_cnt_in;
   logic signed [11:0] cnt_inc;
   logic [2:0]         press;
   logic [2:0]         rep;

   always_comb begin
      confirmed_in = confirmed_ff;
      candidate_in = candidate_ff;
      press        = KEY_NONE;
      if (held_key == KEY_NONE) begin
         candidate_in = KEY_NONE;
         confirmed_in = KEY_NONE;
      end else if (confirmed_ff == held_key) begin
         press = KEY_NONE;
      end else if (candidate_ff == KEY_NONE || candidate_ff != held_key) begin
         candidate_in = held_key;
         confirmed_in = KEY_NONE;
      end else begin
         confirmed_in = held_key;
         press        = held_key;
      end
   end

   assign cnt_inc = rpt_cnt_ff + 12'sd1;

   always_comb begin
      rpt_cnt_in = rpt_cnt_ff;
      ref_key_in = ref_key_ff;
      rep        = KEY_NONE;
      if (press != KEY_NONE) begin
         rpt_cnt_in = 12'(repeat_start);
      end else if (cnt_inc < $signed({2'b00, repeat_period})) begin
         rpt_cnt_in = cnt_inc;
         ref_key_in = held_key;
      end else begin
         rpt_cnt_in = '0;
         if (ref_key_ff == held_key) rep = held_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         confirmed_ff <= KEY_NONE;
         candidate_ff <= KEY_NONE;
         ref_key_ff   <= KEY_NONE;
         rpt_cnt_ff   <= '0;
      end else if (tick_en) begin
         confirmed_ff <= confirmed_in;
         candidate_ff <= candidate_in;
         ref_key_ff   <= ref_key_in;
         rpt_cnt_ff   <= rpt_cnt_in;
      end
   end

   assign tick_evt.press       = press;
   assign tick_evt.repeat_code = rep;

endmodule

// ===== tb/sv/keypad_scan_checker.sv =====
// Checker for the keypad scanner: shadow decoder and in-order comparison of report beats.
module keypad_scan_checker import alks_pkg::*; #(
   parameter int AVG_SHIFT = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  alks_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  alks_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [10:0]  csr_wdata,
   output int           fail_count,
   output int           reports_due
);

   localparam logic [9:0] JUMP_MAX = 10'd115;

   // shadow copy of registers and scanner state
   logic signed [10:0] rpt_start;
   logic        [9:0]  rpt_period;
   logic [9:0]         prev_key;
   logic [15:0]        key_sum;
   logic [6:0]         key_count;
   logic [2:0]         cur_key;
   logic [2:0]         cur_aux;
   logic [2:0]         cand_key;
   logic [2:0]         conf_key;
   logic [2:0]         rpt_key;
   logic signed [11:0] rpt_count;

   alks_rsp_type reports_q[$];
   int           bad;

   // Advance the shadow state by one request beat and return the report it should give.
   function automatic alks_rsp_type decode_beat(input alks_req_type beat);
      alks_rsp_type rpt;
      logic [9:0]   gap;
      logic [15:0]  mean;
      logic [2:0]   press;
      logic [2:0]   again;
      int           nxt;
      press = KEY_NONE;
      again = KEY_NONE;
      if (beat.req_type == REQ_SAMPLE) begin
         gap = (beat.key_sample > prev_key) ? beat.key_sample - prev_key
                                            : prev_key - beat.key_sample;
         if (gap > JUMP_MAX) begin
            key_sum   = 16'd0;
            key_count = 7'd0;
         end else begin
            key_sum   = key_sum + 16'(beat.key_sample);
            key_count = key_count + 7'd1;
            if (key_count == 7'(1 << AVG_SHIFT)) begin
               key_count = 7'd0;
               mean = key_sum >> AVG_SHIFT;
               if (beat.power_pressed)                        cur_key = KEY_POWER;
               else if (mean >= 16'd821 && mean <= 16'd860)   cur_key = KEY_INC;
               else if (mean >= 16'd711 && mean <= 16'd750)   cur_key = KEY_DEC;
               else if (mean >= 16'd601 && mean <= 16'd640)   cur_key = KEY_CHAN;
               else if (mean >= 16'd341 && mean <= 16'd380)   cur_key = KEY_MROOM;
               else                                           cur_key = KEY_NONE;
               key_sum = 16'd0;
               // aux bands have exclusive bounds on both sides
               if (beat.aux_sample > 10'h0B8 && beat.aux_sample < 10'h0D8)      cur_aux = AUX_BAND1;
               else if (beat.aux_sample > 10'h188 && beat.aux_sample < 10'h1B0) cur_aux = AUX_BAND2;
               else if (beat.aux_sample > 10'h248 && beat.aux_sample < 10'h288) cur_aux = AUX_BAND3;
               else if (beat.aux_sample > 10'h314 && beat.aux_sample < 10'h340) cur_aux = AUX_BAND4;
               else                                                             cur_aux = AUX_NONE;
            end
         end
         prev_key = beat.key_sample;
      end else begin
         // debounce: two equal reads confirm, one press per hold
         if (cur_key == KEY_NONE) begin
            cand_key = KEY_NONE;
            conf_key = KEY_NONE;
         end else if (conf_key != cur_key) begin
            if (cand_key == cur_key) begin
               conf_key = cur_key;
               press    = cur_key;
            end else begin
               cand_key = cur_key;
               conf_key = KEY_NONE;
            end
         end
         // auto-repeat
         if (press != KEY_NONE) begin
            rpt_count = {rpt_start[10], rpt_start};
         end else begin
            nxt = int'(rpt_count) + 1;
            if (nxt < int'(rpt_period)) begin
               rpt_count = 12'(nxt);
               rpt_key   = cur_key;
            end else begin
               rpt_count = 12'sd0;
               if (rpt_key == cur_key) again = cur_key;
            end
         end
      end
      rpt.held_code    = cur_key;
      rpt.aux_code     = cur_aux;
      rpt.press_event  = press;
      rpt.repeat_event = again;
      return rpt;
   endfunction

   always @(posedge clock) begin : watch
      alks_rsp_type want;
      if (reset) begin
         rpt_start  = REPEAT_START_RST;
         rpt_period = REPEAT_PERIOD_RST;
         prev_key   = '0;
         key_sum    = '0;
         key_count  = '0;
         cur_key    = KEY_NONE;
         cur_aux    = AUX_NONE;
         cand_key   = KEY_NONE;
         conf_key   = KEY_NONE;
         rpt_key    = KEY_NONE;
         rpt_count  = '0;
         reports_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_REPEAT_START:  rpt_start  = signed'(csr_wdata);
               CSR_REPEAT_PERIOD: rpt_period = csr_wdata[9:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) reports_q.push_back(decode_beat(req_data));
         if (rsp_valid && rsp_ready) begin
            if (reports_q.size() == 0) begin
               if (bad < 10)
                  $display("%0t: unexpected report beat: key %0d aux %0d press %0d repeat %0d",
                           $time, rsp_data.held_code, rsp_data.aux_code,
                           rsp_data.press_event, rsp_data.repeat_event);
               bad++;
            end else begin
               want = reports_q.pop_front();
               if (rsp_data.held_code !== want.held_code ||
                   rsp_data.aux_code !== want.aux_code ||
                   rsp_data.press_event !== want.press_event ||
                   rsp_data.repeat_event !== want.repeat_event) begin
                  if (bad < 10)
                     $display("%0t: report mismatch: exp key %0d aux %0d press %0d repeat %0d, %s",
                              $time, want.held_code, want.aux_code, want.press_event,
                              want.repeat_event,
                              $sformatf("got key %0d aux %0d press %0d repeat %0d",
                                        rsp_data.held_code, rsp_data.aux_code,
                                        rsp_data.press_event, rsp_data.repeat_event));
                  bad++;
               end
            end
         end
      end
      fail_count  <= bad;
      reports_due <= reports_q.size();
   end

endmodule

// ===== tb/sv/tb_adc_ladder_keypad_scanner.sv =====
// Testbench top for the ADC ladder keypad scanner: stimulus, flow control and verdict.
module tb_adc_ladder_keypad_scanner;
   import alks_pkg::*;

   localparam int AVG_SHIFT   = 3;
   localparam int PHASE_BEATS = 200;    // random request beats per register setting
   localparam int JAM_CYCLES  = 60;     // long receiver hold-off
   localparam int LIMIT       = 400000; // cycle budget for the whole run
   localparam int NKEY        = 22;
   localparam int NAUX        = 18;

   // register settings per phase; the last phase picks its own at random
   localparam logic signed [10:0] START_SET [5] = '{-11'sd1024, 11'sd1023, 11'sd0,
                                                     -11'sd3, 11'sd5};
   localparam logic [9:0] PERIOD_SET [5] = '{10'd1, 10'd1023, 10'd0, 10'd2, 10'd4};

   // ladder levels around every key window edge, plus the rails
   localparam int KEY_EDGES [NKEY] = '{0, 340, 341, 360, 380, 381, 600, 601, 620, 640, 641,
                                       710, 711, 730, 750, 751, 820, 821, 840, 860, 861, 1023};
   // aux readings on and just inside each band bound
   localparam int AUX_EDGES [NAUX] = '{'h0B8, 'h0B9, 'h0C8, 'h0D7, 'h0D8, 'h188, 'h189, 'h1AF,
                                       'h1B0, 'h248, 'h249, 'h287, 'h288, 'h314, 'h315, 'h33F,
                                       'h340, 'h3FF};

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   alks_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   alks_rsp_type rsp_data;
   logic         csr_we    = 1'b0;
   logic         csr_index = CSR_REPEAT_START;
   logic [10:0]  csr_wdata = '0;

   logic idle_mode = 1'b0;   // random bubbles allowed on both sides
   logic jam_now   = 1'b0;   // asks the receiver for its one long hold-off
   int   fail_count;
   int   reports_due;
   int   sent   = 0;
   int   cycles = 0;

   adc_ladder_keypad_scanner #(.AVG_SHIFT(AVG_SHIFT)) DUT (.*);

   keypad_scan_checker #(.AVG_SHIFT(AVG_SHIFT)) u_checker (.*);

   always #1 clock = ~clock;

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver side: random stall bursts while idle_mode is set, and one long
   // hold-off when the stimulus asks for it so the block backs up into req_ready.
   initial begin : rsp_side
      bit jam_done;
      jam_done = 1'b0;
      forever begin
         @(posedge clock);
         if (jam_now && !jam_done) begin
            jam_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (JAM_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_mode && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One request beat. An optional bubble comes first; once valid rises it
   // holds with a fixed payload until the beat is taken.
   task automatic send_beat(input alks_req_type beat);
      if (idle_mode && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_sample(input logic [9:0] key, input logic [9:0] aux, input logic pwr);
      alks_req_type b;
      b.req_type      = REQ_SAMPLE;
      b.key_sample    = key;
      b.aux_sample    = aux;
      b.power_pressed = pwr;
      send_beat(b);
   endtask

   // scan tick; the ladder fields are don't-care, so fill them with noise
   task automatic send_tick();
      alks_req_type b;
      b.req_type      = REQ_TICK;
      b.key_sample    = 10'($urandom_range(0, 1023));
      b.aux_sample    = 10'($urandom_range(0, 1023));
      b.power_pressed = 1'($urandom_range(0, 1));
      send_beat(b);
   endtask

   // A key held on the ladder: a run of readings near one level (exact or with
   // a little jitter), then some scan ticks. A broken run puts one big jump in
   // the middle, which throws the averaging back to the start.
   task automatic hold_key_seq(input bit broken);
      int level;
      int aux;
      int jit;
      int len;
      int cut;
      int k;
      bit pwr;
      level = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 1023))
                                          : KEY_EDGES[$urandom_range(0, NKEY - 1)];
      aux   = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 1023))
                                          : AUX_EDGES[$urandom_range(0, NAUX - 1)];
      pwr   = ($urandom_range(0, 5) == 0);
      jit   = int'($urandom_range(0, 1)) * 3;
      len   = $urandom_range(6, 12);
      cut   = broken ? int'($urandom_range(1, len - 1)) : len;
      for (int i = 0; i < len; i++) begin
         k = level + int'($urandom_range(0, 2 * jit)) - jit;
         if (i == cut) k = (level + 512) % 1024;
         if (k < 0) k = 0;
         else if (k > 1023) k = 1023;
         send_sample(k[9:0], aux[9:0], pwr);
      end
      repeat ($urandom_range(1, 8)) send_tick();
   endtask

   // stop offering and wait until every report beat has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      alks_req_type       b;
      logic signed [10:0] start_val;
      logic [9:0]         period_val;
      int                 goal;
      int                 pick;

      repeat (10) @(posedge clock);
      reset     <= 1'b0;
      idle_mode <= 1'b1;

      // ---- directed part, registers at their reset values ----
      // tick at reset with every payload bit set: payload must be ignored
      b          = '1;
      b.req_type = REQ_TICK;
      send_beat(b);
      send_sample(10'd0, 10'd0, 1'b0);         // zero reading, first accumulated beat
      send_sample(10'd1023, 10'd1023, 1'b1);   // full-scale jump restarts averaging
      // jump down to the inc window, then seven more to fill the average ...
      repeat (8) send_sample(10'd840, 10'h0C0, 1'b0);
      // ... and the eighth with the power pin up: power wins, aux lands in band 2
      send_sample(10'd840, 10'h1A0, 1'b1);
      repeat (3) send_tick();                  // candidate, press, then hold
      send_sample(10'd0, 10'h3FF, 1'b0);       // jump to ground
      send_sample(10'd115, 10'h000, 1'b0);     // step of exactly the limit: accumulates
      send_sample(10'd231, 10'h000, 1'b0);     // one over the limit: restarts
      repeat (2) send_tick();
      drain();

      // ---- random phases, one register setting each ----
      for (int ph = 0; ph < 6; ph++) begin
         if (ph < 5) begin
            start_val  = START_SET[ph];
            period_val = PERIOD_SET[ph];
         end else begin
            start_val  = 11'($urandom_range(0, 16)) - 11'sd8;
            period_val = 10'($urandom_range(1, 6));
         end
         // block is idle here: nothing outstanding, nothing offered
         csr_we    <= 1'b1;
         csr_index <= CSR_REPEAT_START;
         csr_wdata <= start_val;
         @(posedge clock);
         csr_index <= CSR_REPEAT_PERIOD;
         csr_wdata <= {1'b0, period_val};
         @(posedge clock);
         csr_we <= 1'b0;

         if (ph == 2) begin
            // back-to-back beats against a stalled receiver
            jam_now   <= 1'b1;
            idle_mode <= 1'b0;
            repeat (5) hold_key_seq(1'b0);
            jam_now <= 1'b0;
         end

         // last phase runs with no bubbles on either side
         if (ph == 5) idle_mode <= 1'b0;
         goal = sent + PHASE_BEATS;
         while (sent < goal) begin
            if (ph != 5) idle_mode <= ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
               hold_key_seq(1'b0);
            end else if (pick <= 7) begin
               // long tick runs reach the auto-repeat checks
               repeat ($urandom_range(1, 24)) send_tick();
            end else if (pick == 8) begin
               repeat ($urandom_range(1, 6))
                  send_sample(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                              1'($urandom_range(0, 1)));
            end else begin
               hold_key_seq(1'b1);
            end
         end
         drain();
      end

      // two-stage pipe: a few quiet cycles catch any stray beat
      repeat (4) @(posedge clock);
      if (fail_count == 0 && reports_due == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/alks_pkg.sv
hw/rtl/alks_tick.sv
hw/rtl/adc_ladder_keypad_scanner.sv
tb/sv/keypad_scan_checker.sv
tb/sv/tb_adc_ladder_keypad_scanner.sv
